FILE: hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros for the RC4 engine checkers.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted (active low).
`define RC4_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted (active low).
`define RC4_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

// Next-cycle implication that is also checked across reset.
`define RC4_ASSERT_ALWAYS_NEXT(label, clk, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

FILE: hw/rtl/rc4_pkg.sv
// ----------------------------------------------------------------------------
// rc4_pkg
// Types and constants shared by the RC4 engine, its RAM and its checker.
// ----------------------------------------------------------------------------
package rc4_pkg;

  localparam int BYTE_W        = 8;
  localparam int PERM_DEPTH    = 256;
  localparam int CNT_W         = 9;    // key byte count, holds 0..256
  localparam int KEY_DEPTH_DEF = 256;

  typedef logic [1:0]        mode_t;
  typedef logic [BYTE_W-1:0] byte_t;

  localparam mode_t MODE_CLEAR = 2'd0;
  localparam mode_t MODE_KEY   = 2'd1;
  localparam mode_t MODE_DATA  = 2'd2;

  localparam byte_t IDX_I_INIT = 8'h01;
  localparam byte_t IDX_J_INIT = 8'h00;
  localparam byte_t BYTE_MAX   = 8'hFF;

endpackage

FILE: hw/rtl/rc4_ram.sv
// ----------------------------------------------------------------------------
// rc4_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module rc4_ram #(
  parameter int WIDTH = rc4_pkg::BYTE_W,
  parameter int DEPTH = rc4_pkg::PERM_DEPTH,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // read returns old data on a same-address write
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: hw/rtl/rc4_stream_cipher.sv
// ----------------------------------------------------------------------------
// rc4_stream_cipher
// RC4 engine: key store, key schedule and keystream XOR over one shared
// permutation RAM, run by a small sequencer.
// ----------------------------------------------------------------------------
//
//  channel   ports                                         dir  moves
//  --------  --------------------------------------------  ---  ---------------------
//  in        in_valid in_ready in_mode in_byte_value in_last in   clear / key / data
//  out       out_valid out_ready out_data_out               out  one byte per data req
//
//  A clear request or a key byte without last is done in IDLE; the state stays IDLE.
//  A data byte passes from IDLE through D1, D2 and D3, set by the dependent reads
//  of P[i], P[j] and P[P[i]+P[j]] through the single read port of the permutation RAM.
//  A key byte with last runs the schedule: K0, K1, K2, K3 for each k from 0 to 255.
//  Reset (rst_n low, synchronous) gives identity permutation, i=1, j=0, empty key.
//  A data result waits in the output register; the sequencer holds in its last
//  step only while that register is still full.
//
// ----------------------------------------------------------------------------
module rc4_stream_cipher #(
  parameter int KEY_DEPTH = rc4_pkg::KEY_DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  rc4_pkg::mode_t      in_mode,
  input  rc4_pkg::byte_t      in_byte_value,
  input  logic                in_last,
  output logic                out_valid,
  input  logic                out_ready,
  output rc4_pkg::byte_t      out_data_out
);

  localparam int KW    = (KEY_DEPTH > 1) ? $clog2(KEY_DEPTH) : 1;
  localparam int PW    = $clog2(rc4_pkg::PERM_DEPTH);
  localparam int CNT_W = rc4_pkg::CNT_W;

  // sequencer states
  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_D1   = 3'd1;  // P[i] back, read P[j]
  localparam logic [2:0] ST_D2   = 3'd2;  // P[j] back, write P[i], read P[a+b]
  localparam logic [2:0] ST_D3   = 3'd3;  // write P[j], emit result
  localparam logic [2:0] ST_K0   = 3'd4;  // read P[k] and key[pos]
  localparam logic [2:0] ST_K1   = 3'd5;  // acc update, read P[acc]
  localparam logic [2:0] ST_K2   = 3'd6;  // P[k] <= P[acc]
  localparam logic [2:0] ST_K3   = 3'd7;  // P[acc] <= held, step k

  logic [2:0]          state_r, state_nxt;
  rc4_pkg::byte_t      i_r, i_nxt;
  rc4_pkg::byte_t      j_r, j_nxt;
  rc4_pkg::byte_t      a_r, a_nxt;       // P[i] on data path, held P[k] in schedule
  rc4_pkg::byte_t      b_r, b_nxt;
  rc4_pkg::byte_t      t_r, t_nxt;       // keystream address a+b
  rc4_pkg::byte_t      acc_r, acc_nxt;
  rc4_pkg::byte_t      k_r, k_nxt;
  logic [KW-1:0]       pos_r, pos_nxt;
  logic [CNT_W-1:0]    key_count_r, key_count_nxt;
  rc4_pkg::byte_t      data_r, data_nxt;
  logic                out_valid_r, out_valid_nxt;
  rc4_pkg::byte_t      out_data_r, out_data_nxt;

  // permutation RAM, with one valid bit per entry: invalid reads as its index
  logic                        p_we, p_re;
  logic [PW-1:0]               p_waddr, p_raddr;
  rc4_pkg::byte_t              p_wdata, p_rdata;
  logic [rc4_pkg::PERM_DEPTH-1:0] vld_r;
  logic                        vld_q_r;
  logic [PW-1:0]               raddr_q_r;
  logic                        clear_all;
  rc4_pkg::byte_t              rd_eff;

  // key store RAM
  logic                        k_we, k_re;
  logic [KW-1:0]               k_waddr;
  rc4_pkg::byte_t              k_rdata;

  logic                        in_acc;
  logic                        out_free;
  rc4_pkg::byte_t              ks;

  assign in_ready     = (state_r == ST_IDLE);
  assign in_acc       = in_valid && in_ready;
  assign out_free     = !out_valid_r || out_ready;
  assign out_valid    = out_valid_r;
  assign out_data_out = out_data_r;

  assign rd_eff = vld_q_r ? p_rdata : raddr_q_r;

  // keystream byte after the swap: P[j] now holds a, P[i] now holds b
  assign ks = (t_r == j_r) ? a_r : ((t_r == i_r) ? b_r : rd_eff);

  rc4_ram #(
    .WIDTH (rc4_pkg::BYTE_W),
    .DEPTH (rc4_pkg::PERM_DEPTH)
  ) u_perm_ram (
    .clk   (clk),
    .we    (p_we),
    .waddr (p_waddr),
    .wdata (p_wdata),
    .re    (p_re),
    .raddr (p_raddr),
    .rdata (p_rdata)
  );

  rc4_ram #(
    .WIDTH (rc4_pkg::BYTE_W),
    .DEPTH (KEY_DEPTH)
  ) u_key_ram (
    .clk   (clk),
    .we    (k_we),
    .waddr (k_waddr),
    .wdata (in_byte_value),
    .re    (k_re),
    .raddr (pos_r),
    .rdata (k_rdata)
  );

  assign k_waddr = key_count_r[KW-1:0];

  always_comb begin
    state_nxt     = state_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    a_nxt         = a_r;
    b_nxt         = b_r;
    t_nxt         = t_r;
    acc_nxt       = acc_r;
    k_nxt         = k_r;
    pos_nxt       = pos_r;
    key_count_nxt = key_count_r;
    data_nxt      = data_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    p_we          = 1'b0;
    p_waddr       = i_r;
    p_wdata       = a_r;
    p_re          = 1'b0;
    p_raddr       = i_r;
    k_we          = 1'b0;
    k_re          = 1'b0;
    clear_all     = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          case (in_mode)
            rc4_pkg::MODE_CLEAR: begin
              clear_all     = 1'b1;
              i_nxt         = rc4_pkg::IDX_I_INIT;
              j_nxt         = rc4_pkg::IDX_J_INIT;
              key_count_nxt = '0;
            end
            rc4_pkg::MODE_KEY: begin
              if (key_count_r < CNT_W'(KEY_DEPTH)) begin
                k_we          = 1'b1;
                key_count_nxt = key_count_r + CNT_W'(1);
              end
              if (in_last) begin
                // schedule starts from the identity permutation
                clear_all = 1'b1;
                i_nxt     = rc4_pkg::IDX_I_INIT;
                j_nxt     = rc4_pkg::IDX_J_INIT;
                acc_nxt   = '0;
                k_nxt     = '0;
                pos_nxt   = '0;
                state_nxt = ST_K0;
              end
            end
            rc4_pkg::MODE_DATA: begin
              data_nxt  = in_byte_value;
              p_re      = 1'b1;
              p_raddr   = i_r;
              state_nxt = ST_D1;
            end
            default: begin
              // unused mode: no effect
            end
          endcase
        end
      end
      ST_D1: begin
        a_nxt     = rd_eff;
        j_nxt     = j_r + rd_eff;
        p_re      = 1'b1;
        p_raddr   = j_nxt;
        state_nxt = ST_D2;
      end
      ST_D2: begin
        b_nxt     = rd_eff;
        t_nxt     = a_r + rd_eff;
        p_we      = 1'b1;
        p_waddr   = i_r;
        p_wdata   = rd_eff;
        p_re      = 1'b1;
        p_raddr   = t_nxt;
        state_nxt = ST_D3;
      end
      ST_D3: begin
        // RAM read data holds here (no read issued) while the output is full
        if (out_free) begin
          p_we          = 1'b1;
          p_waddr       = j_r;
          p_wdata       = a_r;
          i_nxt         = i_r + 8'd1;
          out_valid_nxt = 1'b1;
          out_data_nxt  = data_r ^ ks;
          state_nxt     = ST_IDLE;
        end
      end
      ST_K0: begin
        p_re      = 1'b1;
        p_raddr   = k_r;
        k_re      = 1'b1;
        state_nxt = ST_K1;
      end
      ST_K1: begin
        a_nxt     = rd_eff;
        acc_nxt   = acc_r + k_rdata + rd_eff;
        p_re      = 1'b1;
        p_raddr   = acc_nxt;
        state_nxt = ST_K2;
      end
      ST_K2: begin
        p_we      = 1'b1;
        p_waddr   = k_r;
        p_wdata   = rd_eff;
        state_nxt = ST_K3;
      end
      ST_K3: begin
        p_we    = 1'b1;
        p_waddr = acc_r;
        p_wdata = a_r;
        k_nxt   = k_r + 8'd1;
        // key bytes taken cyclically over the stored count
        if ((CNT_W'(pos_r) + CNT_W'(1)) >= key_count_r) begin
          pos_nxt = '0;
        end else begin
          pos_nxt = pos_r + KW'(1);
        end
        if (k_r == rc4_pkg::BYTE_MAX) begin
          key_count_nxt = '0;
          state_nxt     = ST_IDLE;
        end else begin
          state_nxt = ST_K0;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      i_r         <= rc4_pkg::IDX_I_INIT;
      j_r         <= rc4_pkg::IDX_J_INIT;
      key_count_r <= '0;
      out_valid_r <= 1'b0;
      vld_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      i_r         <= i_nxt;
      j_r         <= j_nxt;
      key_count_r <= key_count_nxt;
      out_valid_r <= out_valid_nxt;
      if (clear_all) begin
        vld_r <= '0;
      end else if (p_we) begin
        vld_r[p_waddr] <= 1'b1;
      end
    end
  end

  // payload and working registers
  always_ff @(posedge clk) begin
    a_r        <= a_nxt;
    b_r        <= b_nxt;
    t_r        <= t_nxt;
    acc_r      <= acc_nxt;
    k_r        <= k_nxt;
    pos_r      <= pos_nxt;
    data_r     <= data_nxt;
    out_data_r <= out_data_nxt;
    if (p_re) begin
      vld_q_r   <= vld_r[p_raddr];
      raddr_q_r <= p_raddr;
    end
  end

endmodule

FILE: hw/rtl/rc4_checker.sv
// ----------------------------------------------------------------------------
// rc4_checker
// Port-level checks on the RC4 engine, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rc4_checker (
  input logic           clk,
  input logic           rst_n,
  input logic           in_valid,
  input logic           in_ready,
  input rc4_pkg::mode_t in_mode,
  input logic           in_last,
  input logic           out_valid,
  input logic           out_ready,
  input rc4_pkg::byte_t out_data_out
);

  logic in_acc;
  logic data_req;
  logic sched_req;
  logic clear_req;

  assign in_acc    = in_valid && in_ready;
  assign data_req  = in_acc && (in_mode == rc4_pkg::MODE_DATA);
  assign sched_req = in_acc && (in_mode == rc4_pkg::MODE_KEY) && in_last;
  assign clear_req = in_acc && (in_mode == rc4_pkg::MODE_CLEAR);

  // a pending result holds until taken
  `RC4_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_data_out))

  // data and schedule requests keep the engine busy the next cycle
  `RC4_ASSERT_NEXT(a_busy_after_work, clk, rst_n, data_req || sched_req, !in_ready)

  // a clear leaves the engine ready in the next cycle
  `RC4_ASSERT_NEXT(a_clear_one_cycle, clk, rst_n, clear_req, in_ready)

  // a data request holds off new requests for its three RAM steps
  `RC4_ASSERT_SAME(a_data_busy, clk, rst_n, data_req, ##1 (!in_ready [*3]))

  // reset empties the output register
  `RC4_ASSERT_ALWAYS_NEXT(a_reset_out, clk, !rst_n, !out_valid)

endmodule

bind rc4_stream_cipher rc4_checker u_rc4_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_valid),
  .in_ready     (in_ready),
  .in_mode      (in_mode),
  .in_last      (in_last),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .out_data_out (out_data_out)
);
